>>> src/uvs_pkg.sv
// Shared types, constants and fixed-point helpers for the UV sphere vertex generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;
	localparam int MAX_SLICES_DEF = 32;
	localparam int MAX_STACKS_DEF = 32;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int CELL_VERTS = 6;
	localparam int IDX_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THETA_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHI_STEP = 2'd2;

	localparam logic signed [33:0] C1 = 34'sd1686629713;
	localparam logic signed [33:0] C3 = 34'sd693598669;
	localparam logic signed [33:0] C5 = 34'sd85569305;
	localparam logic signed [33:0] C7 = 34'sd5026995;
	localparam logic signed [33:0] C9 = 34'sd172272;

	localparam logic [CELL_VERTS-1:0] CORNER_DX = 6'b101010;
	localparam logic [CELL_VERTS-1:0] CORNER_DY = 6'b110001;

	typedef struct packed {
		logic [IDX_W-1:0] x;
		logic [IDX_W-1:0] y;
	} cell_t;

	typedef struct packed {
		logic [23:0] radius;
		logic [15:0] theta_step;
		logic [15:0] phi_step;
	} cfg_t;

	// Q16 product, rounded half away from zero
	function automatic logic signed [26:0] mul_q16(input logic signed [24:0] a,
		input logic signed [17:0] b);
		logic [24:0] ma;
		logic [17:0] mb;
		logic [42:0] pr;
		logic [26:0] r;
		logic neg;
		neg = a[24] ^ b[17];
		ma = a[24] ? 25'(-a) : 25'(a);
		mb = b[17] ? 18'(-b) : 18'(b);
		pr = 43'(ma) * 43'(mb);
		r = 27'((pr + 43'd32768) >> 16);
		mul_q16 = neg ? -$signed(r) : $signed(r);
	endfunction
endpackage
`default_nettype wire

>>> src/uv_sphere_cell_vertex_generator.sv
// Top level of the UV sphere cell vertex generator: configuration registers,
// front queue and vertex back end. Depends on uvs_pkg, uvs_front, uvs_back.
//
// Use: a cell request (slice_index, stack_index) is taken at a clock edge with
// start high and busy low. Each cell yields six vertices, one per cycle, each
// shown for one cycle with vertex_valid high; corner counts 0..5 and last marks
// the sixth. The receiver cannot stall, so vertices leave as they are made.
// The single vertex pipeline produces one vertex a cycle; a two-entry request
// queue keeps it fed, and busy rises only when both entries wait.
// Configuration: cfg_write with cfg_index 0 radius, 1 theta step, 2 phi step;
// other indices are ignored. Write only while the block is idle.
// Reset: arst_n clears the queue and the pipeline and loads radius 1.0,
// theta step 3277 and phi step 1638.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_cell_vertex_generator #(
	parameter int MAX_SLICES = uvs_pkg::MAX_SLICES_DEF,
	parameter int MAX_STACKS = uvs_pkg::MAX_STACKS_DEF,
	parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_write,
	input  wire [uvs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [uvs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           start,
	output logic                          busy,
	input  wire [uvs_pkg::IDX_W-1:0]      slice_index,
	input  wire [uvs_pkg::IDX_W-1:0]      stack_index,
	output logic                          vertex_valid,
	output logic signed [24:0]            pos_x,
	output logic signed [24:0]            pos_y,
	output logic signed [24:0]            pos_z,
	output logic signed [17:0]            norm_x,
	output logic signed [17:0]            norm_y,
	output logic signed [17:0]            norm_z,
	output logic [16:0]                   tex_u,
	output logic [16:0]                   tex_v,
	output logic [2:0]                    corner,
	output logic                          last
);
	import uvs_pkg::*;

	cfg_t cfg_q;
	cell_t grid_cell;
	logic cell_valid, cell_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= 24'd65536;
			cfg_q.theta_step <= 16'd3277;
			cfg_q.phi_step <= 16'd1638;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_RADIUS: cfg_q.radius <= cfg_data;
				REG_THETA_STEP: cfg_q.theta_step <= cfg_data[15:0];
				REG_PHI_STEP: cfg_q.phi_step <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	uvs_front #(.MAX_SLICES(MAX_SLICES), .MAX_STACKS(MAX_STACKS)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start),
		.slice_index(slice_index), .stack_index(stack_index),
		.busy(busy), .cell_valid(cell_valid), .grid_cell(grid_cell), .cell_pop(cell_pop)
	);

	uvs_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.cell_valid(cell_valid), .grid_cell(grid_cell), .cell_pop(cell_pop),
		.vertex_valid(vertex_valid),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.tex_u(tex_u), .tex_v(tex_v), .corner(corner), .last(last)
	);
endmodule
`default_nettype wire

>>> src/uvs_front.sv
// Front end: accepts cell requests, clamps indices, holds them in a two-entry queue.
// Depends on uvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uvs_front #(
	parameter int MAX_SLICES = 32,
	parameter int MAX_STACKS = 32
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	input  wire [uvs_pkg::IDX_W-1:0]  slice_index,
	input  wire [uvs_pkg::IDX_W-1:0]  stack_index,
	output logic                      busy,
	output logic                      cell_valid,
	output uvs_pkg::cell_t            grid_cell,
	input  wire                       cell_pop
);
	import uvs_pkg::*;

	cell_t mem_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	cell_t in_cell;
	logic push;

	always_comb begin
		in_cell.x = (32'(slice_index) > MAX_SLICES - 1) ? IDX_W'(MAX_SLICES - 1) : slice_index;
		in_cell.y = (32'(stack_index) > MAX_STACKS - 1) ? IDX_W'(MAX_STACKS - 1) : stack_index;
	end

	assign busy = cnt_q[1];
	assign push = start && !busy;
	assign cell_valid = (cnt_q != 2'd0);
	assign grid_cell = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cell;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (cell_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(cell_pop);
		end
	end
endmodule
`default_nettype wire

>>> src/uvs_sinq.sv
// Six-stage sine pipeline: quadrant fold, degree-9 Horner polynomial, one multiply a stage.
// Depends on uvs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module uvs_sinq (
	input  wire                clk,
	input  wire [1:0]          quad,
	input  wire [15:0]         frac,
	output logic signed [17:0] sin_out
);
	import uvs_pkg::*;

	logic [16:0] tm;
	logic [33:0] tsq;
	logic [16:0] t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [16:0] t2_s1, t2_s2, t2_s3, t2_s4;
	logic neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic signed [33:0] p_s2, p_s3, p_s4, p_s5;
	logic signed [51:0] m2, m3, m4, m5;
	logic [33:0] pc;
	logic [50:0] fin;
	logic [20:0] s;
	logic [16:0] sc;

	assign tm = quad[0] ? 17'd65536 - 17'(frac) : 17'(frac);
	assign tsq = 34'(tm) * 34'(tm);

	assign m2 = 52'(C9) * $signed({1'b0, t2_s1});
	assign m3 = 52'(p_s2) * $signed({1'b0, t2_s2});
	assign m4 = 52'(p_s3) * $signed({1'b0, t2_s3});
	assign m5 = 52'(p_s4) * $signed({1'b0, t2_s4});

	always_comb begin
		pc = p_s5[33] ? 34'd0 : 34'(p_s5);
		fin = 51'(pc) * 51'(t_s5) + (51'd1 << 29);
		s = 21'(fin >> 30);
		sc = (s > 21'd65536) ? 17'd65536 : 17'(s);
	end

	always_ff @(posedge clk) begin
		t_s1 <= tm;
		t2_s1 <= 17'(tsq >> 16);
		neg_s1 <= quad[1];
		t_s2 <= t_s1;
		t2_s2 <= t2_s1;
		neg_s2 <= neg_s1;
		p_s2 <= C7 - 34'(m2 >>> 16);
		t_s3 <= t_s2;
		t2_s3 <= t2_s2;
		neg_s3 <= neg_s2;
		p_s3 <= C5 - 34'(m3 >>> 16);
		t_s4 <= t_s3;
		t2_s4 <= t2_s3;
		neg_s4 <= neg_s3;
		p_s4 <= C3 - 34'(m4 >>> 16);
		t_s5 <= t_s4;
		neg_s5 <= neg_s4;
		p_s5 <= C1 - 34'(m5 >>> 16);
		sin_out <= neg_s5 ? -$signed({1'b0, sc}) : $signed({1'b0, sc});
	end
endmodule
`default_nettype wire

>>> src/uvs_back.sv
// Back end: walks the six corners of a queued cell, one vertex a cycle, through
// the trig lanes and the normal and position multipliers. Depends on uvs_pkg, uvs_sinq.
`timescale 1ns / 1ps
`default_nettype none
module uvs_back #(
	parameter int ANGLE_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire uvs_pkg::cfg_t cfg,
	input  wire                cell_valid,
	input  wire uvs_pkg::cell_t grid_cell,
	output logic               cell_pop,
	output logic               vertex_valid,
	output logic signed [24:0] pos_x,
	output logic signed [24:0] pos_y,
	output logic signed [24:0] pos_z,
	output logic signed [17:0] norm_x,
	output logic signed [17:0] norm_y,
	output logic signed [17:0] norm_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic [2:0]         corner,
	output logic               last
);
	import uvs_pkg::*;

	localparam int DLY = 7;

	typedef struct packed {
		logic [16:0] u;
		logic [16:0] v;
		logic [2:0]  corner;
		logic        last;
	} side_t;

	logic [2:0] k_q;
	logic vld_s1;
	logic [21:0] theta_s1, phi_s1;
	logic [2:0] k_s1;
	logic [5:0] xi, yi;

	logic [39:0] tae, pae;
	logic [ANGLE_BITS-1:0] ta, pa;
	logic [ANGLE_BITS+15:0] tfe, pfe;
	logic [15:0] tt, pt;
	logic [1:0] tq, pq;
	logic [22:0] phi2;
	side_t side_in;

	side_t side_q [DLY];
	logic [DLY-1:0] vld_q;

	logic signed [17:0] st, ct, sp, cp;
	logic signed [17:0] nx_p1, ny_p1, nz_p1;
	logic signed [26:0] mx, my, rx, ry, rz;
	logic signed [24:0] rad;

	assign cell_pop = cell_valid && (k_q == 3'(CELL_VERTS - 1));
	assign xi = 6'(grid_cell.x) + 6'(CORNER_DX[k_q]);
	assign yi = 6'(grid_cell.y) + 6'(CORNER_DY[k_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= 3'd0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cell_valid;
			if (cell_valid) begin
				k_q <= cell_pop ? 3'd0 : k_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		theta_s1 <= 22'(xi) * 22'(cfg.theta_step);
		phi_s1 <= 22'(yi) * 22'(cfg.phi_step);
		k_s1 <= k_q;
	end

	always_comb begin
		tae = {theta_s1[15:0], 24'd0};
		pae = {phi_s1[15:0], 24'd0};
		ta = tae[39 -: ANGLE_BITS];
		pa = pae[39 -: ANGLE_BITS];
		tfe = {ta[ANGLE_BITS-3:0], 18'd0};
		pfe = {pa[ANGLE_BITS-3:0], 18'd0};
		tt = tfe[ANGLE_BITS+15 -: 16];
		pt = pfe[ANGLE_BITS+15 -: 16];
		tq = ta[ANGLE_BITS-1 -: 2];
		pq = pa[ANGLE_BITS-1 -: 2];
		phi2 = {phi_s1, 1'b0};
		side_in.u = (theta_s1 > 22'd65536) ? 17'd65536 : 17'(theta_s1);
		side_in.v = (phi2 > 23'd65536) ? 17'd65536 : 17'(phi2);
		side_in.corner = k_s1;
		side_in.last = (k_s1 == 3'(CELL_VERTS - 1));
	end

	uvs_sinq u_sin_theta (.clk(clk), .quad(tq), .frac(tt), .sin_out(st));
	uvs_sinq u_cos_theta (.clk(clk), .quad(tq + 2'd1), .frac(tt), .sin_out(ct));
	uvs_sinq u_sin_phi (.clk(clk), .quad(pq), .frac(pt), .sin_out(sp));
	uvs_sinq u_cos_phi (.clk(clk), .quad(pq + 2'd1), .frac(pt), .sin_out(cp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			vertex_valid <= 1'b0;
		end else begin
			vld_q <= {vld_q[DLY-2:0], vld_s1};
			vertex_valid <= vld_q[DLY-1];
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		for (int i = 1; i < DLY; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	assign mx = mul_q16(25'(sp), ct);
	assign my = mul_q16(25'(sp), st);
	assign rad = $signed({1'b0, cfg.radius});
	assign rx = mul_q16(rad, nx_p1);
	assign ry = mul_q16(rad, ny_p1);
	assign rz = mul_q16(rad, nz_p1);

	always_ff @(posedge clk) begin
		nx_p1 <= 18'(mx);
		ny_p1 <= 18'(my);
		nz_p1 <= cp;
		pos_x <= 25'(rx);
		pos_y <= 25'(ry);
		pos_z <= 25'(rz);
		norm_x <= nx_p1;
		norm_y <= ny_p1;
		norm_z <= nz_p1;
		tex_u <= side_q[DLY-1].u;
		tex_v <= side_q[DLY-1].v;
		corner <= side_q[DLY-1].corner;
		last <= side_q[DLY-1].last;
	end
endmodule
`default_nettype wire
